@@ rtl/range_count_greater_sqrt_buckets_top_defines.svh @@
// Assertion macros for the range count block.
// Included by the modules that carry assertions; no other dependencies.
`ifndef RANGE_COUNT_GREATER_SQRT_BUCKETS_TOP_DEFINES_SVH
`define RANGE_COUNT_GREATER_SQRT_BUCKETS_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define RCGS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcgs assertion failed");
// Next-cycle implication, checked out of reset.
`define RCGS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcgs assertion failed");
`else
`define RCGS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RCGS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/rcgs_pkg.sv @@
// Package for the range count block: field widths, parameter defaults,
// function codes and the sequencer state type. No dependencies.
`timescale 1ns / 1ps
package rcgs_pkg;
    localparam int POS_W   = 12;
    localparam int VAL_W   = 16;
    localparam int CNT_W   = 13;

    localparam int BUCKET_SIZE_DEF = 64;
    localparam int NUM_BUCKETS_DEF = 64;
    localparam int VALUE_BITS_DEF  = 16;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_COUNT = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_W_RD,
        S_W_OLD,
        S_W_MERGE,
        S_W_LAST,
        S_C_SETUP,
        S_C_LSET,
        S_C_RSET,
        S_C_FSET,
        S_SRD,
        S_SCMP,
        S_BRD,
        S_BCMP,
        S_OUT
    } t_state;
endpackage

@@ rtl/rcgs_in_if.sv @@
// Input channel of the range count block: valid/ready plus item fields.
// Depends on rcgs_pkg.
`timescale 1ns / 1ps
interface rcgs_in_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [rcgs_pkg::POS_W-1:0]  position;
    logic [rcgs_pkg::POS_W-1:0]  left;
    logic [rcgs_pkg::POS_W-1:0]  right;
    logic [rcgs_pkg::VAL_W-1:0]  value_in;

    modport source (output valid, func, position, left, right, value_in, input ready);
    modport sink   (input valid, func, position, left, right, value_in, output ready);
endinterface

@@ rtl/rcgs_out_if.sv @@
// Output channel of the range count block: valid/ready plus the count.
// Depends on rcgs_pkg.
`timescale 1ns / 1ps
interface rcgs_out_if;
    logic                        valid;
    logic                        ready;
    logic [rcgs_pkg::CNT_W-1:0]  count;

    modport source (output valid, count, input ready);
    modport sink   (input valid, count, output ready);
endinterface

@@ rtl/rcgs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module rcgs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/range_count_greater_sqrt_buckets_top.sv @@
// Range count of values above a threshold over bucketed sorted copies.
// Depends on rcgs_pkg, rcgs_in_if, rcgs_out_if, rcgs_ram and the defines header.
//
//  channel | dir | payload                               | handshake
//  i_in    | in  | func, position, left, right, value_in  | valid/ready
//  o_out   | out | count                                 | valid/ready
//
// After reset a clearing pass writes zero to every address of both RAMs.
// One item at a time. A write is one merge pass through the bucket's sorted copy
// over the sorted RAM port. A count scans the partial end elements through the
// element RAM read port and binary-searches the sorted copy of each full bucket.
// BUCKET_SIZE must be a power of two. A pending result does not block the next
// item; a count waits in its last state until the output register is free.
`timescale 1ns / 1ps
`include "range_count_greater_sqrt_buckets_top_defines.svh"
module range_count_greater_sqrt_buckets_top #(
    parameter int BUCKET_SIZE = rcgs_pkg::BUCKET_SIZE_DEF,
    parameter int NUM_BUCKETS = rcgs_pkg::NUM_BUCKETS_DEF,
    parameter int VALUE_BITS  = rcgs_pkg::VALUE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rcgs_in_if.sink    i_in,
    rcgs_out_if.source o_out
);
    localparam int BW  = $clog2(BUCKET_SIZE);
    localparam int KW  = BW + 1;
    localparam int ARR = BUCKET_SIZE * NUM_BUCKETS;
    localparam int AW  = $clog2(ARR);
    localparam int PW  = ((AW > rcgs_pkg::POS_W) ? AW : rcgs_pkg::POS_W) + 1;
    localparam int CW  = (VALUE_BITS > rcgs_pkg::VAL_W) ? VALUE_BITS : rcgs_pkg::VAL_W;
    localparam int NW  = rcgs_pkg::CNT_W;

    localparam logic [PW-1:0] MASK_P = PW'(BUCKET_SIZE - 1);
    localparam logic [PW-1:0] B_P    = PW'(BUCKET_SIZE);
    localparam logic [PW-1:0] ARR_P  = PW'(ARR);
    localparam logic [PW-1:0] LAST_P = PW'(ARR - 1);
    localparam logic [KW-1:0] B_K    = KW'(BUCKET_SIZE);
    localparam logic [AW-1:0] LAST_A = AW'(ARR - 1);

    rcgs_pkg::t_state r_state, n_state;

    logic [PW-1:0]         r_pos, r_left, r_right, r_hi, r_lo, r_fbe, r_cur, r_end, r_base;
    logic [PW-1:0]         n_pos, n_left, n_right, n_hi, n_lo, n_fbe, n_cur, n_end, n_base;
    logic [VALUE_BITS-1:0] r_val, r_old, r_carry, n_val, n_old, n_carry;
    logic [CW-1:0]         r_thr, n_thr;
    logic                  r_phr, r_skip, r_ins, n_phr, n_skip, n_ins;
    logic [KW-1:0]         r_blo, r_bhi, r_mid, r_i, r_w, n_blo, n_bhi, n_mid, n_i, n_w;
    logic [NW-1:0]         r_acc, r_cnt, n_acc;
    logic [AW-1:0]         r_clr;
    logic                  r_ovld;

    logic                  w_acc_in, w_load_out;
    logic                  e_we, s_we;
    logic [AW-1:0]         e_waddr, e_raddr, s_waddr, s_raddr;
    logic [VALUE_BITS-1:0] e_wdata, s_wdata, e_rdata, s_rdata;
    logic [PW-1:0]         w_in_pos, w_hi_cl, w_lend;

    rcgs_ram #(.WIDTH(VALUE_BITS), .DEPTH(ARR)) u_elem_ram (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_waddr), .i_wdata(e_wdata),
        .i_raddr(e_raddr), .o_rdata(e_rdata)
    );

    rcgs_ram #(.WIDTH(VALUE_BITS), .DEPTH(ARR)) u_sort_ram (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );

    assign i_in.ready  = (r_state == rcgs_pkg::S_IDLE);
    assign w_acc_in    = i_in.valid && i_in.ready;
    assign o_out.valid = r_ovld;
    assign o_out.count = r_cnt;
    assign w_load_out  = (r_state == rcgs_pkg::S_OUT) && (!r_ovld || o_out.ready);
    assign w_in_pos    = PW'(i_in.position);
    assign w_hi_cl     = (r_right > LAST_P) ? LAST_P : r_right;
    assign w_lend      = r_left | MASK_P;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rcgs_pkg::S_CLEAR:   if (r_clr == LAST_A) n_state = rcgs_pkg::S_IDLE;
            rcgs_pkg::S_IDLE: begin
                if (w_acc_in) begin
                    if (i_in.func == rcgs_pkg::FUNC_COUNT) begin
                        n_state = rcgs_pkg::S_C_SETUP;
                    end else if (w_in_pos < ARR_P) begin
                        n_state = rcgs_pkg::S_W_RD;
                    end
                end
            end
            rcgs_pkg::S_W_RD:    n_state = rcgs_pkg::S_W_OLD;
            rcgs_pkg::S_W_OLD:   n_state = rcgs_pkg::S_W_MERGE;
            rcgs_pkg::S_W_MERGE: if (r_i == B_K) n_state = rcgs_pkg::S_W_LAST;
            rcgs_pkg::S_W_LAST:  n_state = rcgs_pkg::S_IDLE;
            rcgs_pkg::S_C_SETUP: begin
                n_state = (r_left > w_hi_cl) ? rcgs_pkg::S_OUT : rcgs_pkg::S_C_LSET;
            end
            rcgs_pkg::S_C_LSET: begin
                n_state = ((r_left & MASK_P) != '0) ? rcgs_pkg::S_SRD : rcgs_pkg::S_C_RSET;
            end
            rcgs_pkg::S_C_RSET: begin
                n_state = (r_lo <= r_hi && (r_hi & MASK_P) != MASK_P)
                        ? rcgs_pkg::S_SRD : rcgs_pkg::S_C_FSET;
            end
            rcgs_pkg::S_C_FSET: begin
                n_state = (r_lo < r_fbe) ? rcgs_pkg::S_BRD : rcgs_pkg::S_OUT;
            end
            rcgs_pkg::S_SRD:     n_state = rcgs_pkg::S_SCMP;
            rcgs_pkg::S_SCMP: begin
                if (r_cur == r_end) begin
                    n_state = r_phr ? rcgs_pkg::S_C_FSET : rcgs_pkg::S_C_RSET;
                end else begin
                    n_state = rcgs_pkg::S_SRD;
                end
            end
            rcgs_pkg::S_BRD: begin
                if (r_blo < r_bhi) begin
                    n_state = rcgs_pkg::S_BCMP;
                end else if (r_base + B_P >= r_fbe) begin
                    n_state = rcgs_pkg::S_OUT;
                end
            end
            rcgs_pkg::S_BCMP:    n_state = rcgs_pkg::S_BRD;
            rcgs_pkg::S_OUT:     if (w_load_out) n_state = rcgs_pkg::S_IDLE;
            default:             n_state = rcgs_pkg::S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_pos = r_pos;  n_left = r_left;  n_right = r_right;  n_hi = r_hi;
        n_lo = r_lo;    n_fbe = r_fbe;    n_cur = r_cur;      n_end = r_end;
        n_base = r_base; n_val = r_val;   n_old = r_old;      n_carry = r_carry;
        n_thr = r_thr;  n_phr = r_phr;    n_skip = r_skip;    n_ins = r_ins;
        n_blo = r_blo;  n_bhi = r_bhi;    n_mid = r_mid;      n_i = r_i;
        n_w = r_w;      n_acc = r_acc;
        e_we = 1'b0;    e_waddr = r_pos[AW-1:0]; e_wdata = r_val;
        e_raddr = r_cur[AW-1:0];
        s_we = 1'b0;    s_waddr = r_base[AW-1:0] | AW'(r_w); s_wdata = r_val;
        s_raddr = r_base[AW-1:0] | AW'(r_mid);
        unique case (r_state)
            rcgs_pkg::S_CLEAR: begin
                e_we = 1'b1;  e_waddr = r_clr;  e_wdata = '0;
                s_we = 1'b1;  s_waddr = r_clr;  s_wdata = '0;
            end
            rcgs_pkg::S_IDLE: begin
                if (w_acc_in) begin
                    n_pos   = w_in_pos;
                    n_base  = w_in_pos & ~MASK_P;
                    n_left  = PW'(i_in.left);
                    n_right = PW'(i_in.right);
                    n_val   = VALUE_BITS'(i_in.value_in);
                    n_thr   = CW'(i_in.value_in);
                end
            end
            rcgs_pkg::S_W_RD: e_raddr = r_pos[AW-1:0];
            rcgs_pkg::S_W_OLD: begin
                n_old   = e_rdata;
                s_raddr = r_base[AW-1:0];
                n_i = KW'(1);  n_w = '0;  n_skip = 1'b0;  n_ins = 1'b0;
            end
            rcgs_pkg::S_W_MERGE: begin
                // drop first copy of old value, insert new one ahead of first entry >= it
                if (!r_skip && s_rdata == r_old) begin
                    n_skip = 1'b1;
                end else if (!r_ins && s_rdata >= r_val) begin
                    s_we = 1'b1;  s_wdata = r_val;  n_carry = s_rdata;  n_ins = 1'b1;
                    n_w = r_w + KW'(1);
                end else if (r_ins) begin
                    s_we = 1'b1;  s_wdata = r_carry;  n_carry = s_rdata;
                    n_w = r_w + KW'(1);
                end else begin
                    s_we = 1'b1;  s_wdata = s_rdata;
                    n_w = r_w + KW'(1);
                end
                s_raddr = r_base[AW-1:0] | AW'(r_i[BW-1:0]);
                if (r_i != B_K) n_i = r_i + KW'(1);
            end
            rcgs_pkg::S_W_LAST: begin
                s_we = 1'b1;  s_wdata = r_ins ? r_carry : r_val;
                e_we = 1'b1;
            end
            rcgs_pkg::S_C_SETUP: begin
                n_hi  = w_hi_cl;
                n_acc = '0;
            end
            rcgs_pkg::S_C_LSET: begin
                n_fbe = ((r_hi & MASK_P) == MASK_P) ? r_hi + PW'(1) : r_hi & ~MASK_P;
                if ((r_left & MASK_P) != '0) begin
                    n_cur = r_left;
                    n_end = (w_lend < r_hi) ? w_lend : r_hi;
                    n_lo  = w_lend + PW'(1);
                    n_phr = 1'b0;
                end else begin
                    n_lo  = r_left;
                end
            end
            rcgs_pkg::S_C_RSET: begin
                n_cur = r_hi & ~MASK_P;
                n_end = r_hi;
                n_phr = 1'b1;
            end
            rcgs_pkg::S_C_FSET: begin
                n_base = r_lo;  n_blo = '0;  n_bhi = B_K;
            end
            rcgs_pkg::S_SRD: e_raddr = r_cur[AW-1:0];
            rcgs_pkg::S_SCMP: begin
                if (CW'(e_rdata) > r_thr) n_acc = r_acc + NW'(1);
                n_cur = r_cur + PW'(1);
            end
            rcgs_pkg::S_BRD: begin
                if (r_blo < r_bhi) begin
                    n_mid   = r_blo + ((r_bhi - r_blo) >> 1);
                    s_raddr = r_base[AW-1:0] | AW'(n_mid);
                end else begin
                    n_acc  = r_acc + NW'(B_K - r_blo);
                    n_base = r_base + B_P;
                    n_blo  = '0;
                    n_bhi  = B_K;
                end
            end
            rcgs_pkg::S_BCMP: begin
                if (CW'(s_rdata) <= r_thr) n_blo = r_mid + KW'(1);
                else                       n_bhi = r_mid;
            end
            rcgs_pkg::S_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcgs_pkg::S_CLEAR;
            r_clr   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == rcgs_pkg::S_CLEAR) r_clr <= r_clr + AW'(1);
            if (w_load_out)        r_ovld <= 1'b1;
            else if (o_out.ready)  r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;  r_left <= n_left;  r_right <= n_right;  r_hi <= n_hi;
        r_lo <= n_lo;    r_fbe <= n_fbe;    r_cur <= n_cur;      r_end <= n_end;
        r_base <= n_base; r_val <= n_val;   r_old <= n_old;      r_carry <= n_carry;
        r_thr <= n_thr;  r_phr <= n_phr;    r_skip <= n_skip;    r_ins <= n_ins;
        r_blo <= n_blo;  r_bhi <= n_bhi;    r_mid <= n_mid;      r_i <= n_i;
        r_w <= n_w;      r_acc <= n_acc;
        if (w_load_out) r_cnt <= r_acc;
    end

    `RCGS_ASSERT_NOW(a_merge_behind, i_clk, i_rst_n, r_state == rcgs_pkg::S_W_MERGE, r_w < r_i)
    `RCGS_ASSERT_NOW(a_bs_bounds, i_clk, i_rst_n, r_state == rcgs_pkg::S_BRD, (r_blo <= r_bhi) && (r_bhi <= B_K))
    `RCGS_ASSERT_NOW(a_cnt_range, i_clk, i_rst_n, r_ovld, r_cnt <= NW'(ARR))
    `RCGS_ASSERT_NEXT(a_count_busy, i_clk, i_rst_n, w_acc_in && (i_in.func == rcgs_pkg::FUNC_COUNT), r_state != rcgs_pkg::S_IDLE)
endmodule

@@ tb/sv/tb_range_count_greater_sqrt_buckets_top.sv @@
// Testbench for range_count_greater_sqrt_buckets_top: directed table then random items,
// counts checked against a flat-array predictor. Depends on rcgs_pkg, rcgs_in_if, rcgs_out_if.
`timescale 1ns / 1ps
module tb_range_count_greater_sqrt_buckets_top;
    localparam int   POS_W           = rcgs_pkg::POS_W;
    localparam int   VAL_W           = rcgs_pkg::VAL_W;
    localparam int   BUCKET_SIZE_DEF = rcgs_pkg::BUCKET_SIZE_DEF;
    localparam logic FUNC_WRITE      = rcgs_pkg::FUNC_WRITE;
    localparam logic FUNC_COUNT      = rcgs_pkg::FUNC_COUNT;

    localparam int ARRAY_SIZE = rcgs_pkg::BUCKET_SIZE_DEF * rcgs_pkg::NUM_BUCKETS_DEF;
    localparam int N_RANDOM   = 630;
    localparam int CALM_TAIL  = 120;
    localparam int STALL_LIM  = 40000;

    typedef struct {
        logic             func;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] left;
        logic [POS_W-1:0] right;
        logic [VAL_W-1:0] value_in;
        bit               has_cnt;
        int               cnt;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    rcgs_in_if  in_ch();
    rcgs_out_if out_ch();

    range_count_greater_sqrt_buckets_top i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    logic [VAL_W-1:0] shadow_vals [ARRAY_SIZE];
    int   pending_counts [$];
    t_row table_rows [$];
    int   n_errors, n_writes, n_counts, n_checked;
    int   idle_cycles;
    bit   calm;
    int   sink_stall;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(string what, int got, int want);
        n_errors++;
        $display("ERR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    task automatic add_row(logic func, logic [POS_W-1:0] pos, logic [POS_W-1:0] lft,
                           logic [POS_W-1:0] rgt, logic [VAL_W-1:0] val,
                           bit typed, int cnt);
        t_row r;
        r.func     = func;
        r.position = pos;
        r.left     = lft;
        r.right    = rgt;
        r.value_in = val;
        r.has_cnt  = typed;
        r.cnt      = cnt;
        table_rows.insert(table_rows.size(), r);
    endtask

    function automatic int count_greater(int lo, int hi, logic [VAL_W-1:0] thr);
        int n;
        n = 0;
        if (hi > ARRAY_SIZE - 1) hi = ARRAY_SIZE - 1;
        for (int p = lo; p <= hi; p++)
            if (shadow_vals[p] > thr) n++;
        return n;
    endfunction

    // apply accepted item to the shadow array, queue any count
    task automatic absorb(t_row r);
        int c;
        if (r.func == FUNC_WRITE) begin
            shadow_vals[r.position] = r.value_in;
            n_writes++;
        end else begin
            c = count_greater(r.left, r.right, r.value_in);
            if (r.has_cnt && c != r.cnt) report_mismatch("table vs predictor", c, r.cnt);
            pending_counts.insert(pending_counts.size(), r.has_cnt ? r.cnt : c);
            n_counts++;
        end
    endtask

    task automatic send_item(t_row r);
        in_ch.valid    <= 1'b1;
        in_ch.func     <= r.func;
        in_ch.position <= r.position;
        in_ch.left     <= r.left;
        in_ch.right    <= r.right;
        in_ch.value_in <= r.value_in;
        do @(posedge i_clk); while (!in_ch.ready);
        absorb(r);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return VAL_W'($urandom_range(0, 7)) << 12;
            3: return VAL_W'($urandom_range(0, 15));
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic t_row random_row();
        t_row r;
        int lo, span;
        r.has_cnt  = 1'b0;
        r.cnt      = 0;
        r.func     = ($urandom_range(0, 1) == 0) ? FUNC_WRITE : FUNC_COUNT;
        r.value_in = pick_value();
        r.position = ($urandom_range(0, 2) == 0) ? POS_W'($urandom_range(0, 191))
                                                 : POS_W'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                lo   = $urandom_range(0, ARRAY_SIZE - 1);
                span = $urandom_range(0, 3 * BUCKET_SIZE_DEF);
                r.left  = POS_W'(lo);
                r.right = POS_W'((lo + span > ARRAY_SIZE - 1) ? ARRAY_SIZE - 1 : lo + span);
            end
            6: begin
                r.left  = POS_W'($urandom_range(0, 191));
                r.right = POS_W'($urandom_range(0, 191));
            end
            7: begin
                r.left  = '0;
                r.right = '1;
            end
            default: begin
                r.left  = POS_W'($urandom);
                r.right = POS_W'($urandom);
            end
        endcase
        return r;
    endfunction

    // output side: random stalls, compare against oldest pending count
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            sink_stall   <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_counts.size() == 0) begin
                    report_mismatch("unexpected count", int'(out_ch.count), -1);
                end else begin
                    if (int'(out_ch.count) != pending_counts[0])
                        report_mismatch("count", int'(out_ch.count), pending_counts[0]);
                    void'(pending_counts.pop_front());
                    n_checked++;
                end
            end
            if (sink_stall > 0) begin
                sink_stall   <= sink_stall - 1;
                out_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                sink_stall   <= $urandom_range(0, 7);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIM) begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIM);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        t_row r;
        n_errors = 0; n_writes = 0; n_counts = 0; n_checked = 0;
        idle_cycles = 0;
        calm = 1'b0;
        for (int p = 0; p < ARRAY_SIZE; p++) shadow_vals[p] = '0;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.func     = FUNC_WRITE;
        in_ch.position = '0;
        in_ch.left     = '0;
        in_ch.right    = '0;
        in_ch.value_in = '0;
        out_ch.ready   = 1'b0;

        //      func        pos      left     right    value     typed  cnt
        add_row(FUNC_COUNT, 12'd0,   12'd0,   12'hFFF, 16'h0000, 1, 0);
        add_row(FUNC_COUNT, 12'd0,   12'd9,   12'd3,   16'h0000, 1, 0);
        add_row(FUNC_WRITE, 12'd0,   12'd0,   12'd0,   16'hFFFF, 0, 0);
        add_row(FUNC_WRITE, 12'hFFF, 12'd0,   12'd0,   16'hFFFF, 0, 0);
        add_row(FUNC_COUNT, 12'd0,   12'd0,   12'hFFF, 16'h0000, 1, 2);
        add_row(FUNC_COUNT, 12'd0,   12'd0,   12'hFFF, 16'hFFFF, 1, 0);
        add_row(FUNC_COUNT, 12'd0,   12'd0,   12'd0,   16'hFFFE, 1, 1);
        add_row(FUNC_COUNT, 12'd0,   12'hFFF, 12'hFFF, 16'hFFFE, 1, 1);
        add_row(FUNC_COUNT, 12'd0,   12'hFFF, 12'd0,   16'h0000, 1, 0);
        add_row(FUNC_WRITE, 12'd5,   12'd0,   12'd0,   16'h0007, 0, 0);
        add_row(FUNC_WRITE, 12'd6,   12'd0,   12'd0,   16'h0007, 0, 0);
        add_row(FUNC_WRITE, 12'd7,   12'd0,   12'd0,   16'h0007, 0, 0);
        add_row(FUNC_WRITE, 12'd6,   12'd0,   12'd0,   16'h0003, 0, 0);
        add_row(FUNC_WRITE, 12'd0,   12'd0,   12'd0,   16'h0000, 0, 0);
        add_row(FUNC_WRITE, 12'd63,  12'd0,   12'd0,   16'h8000, 0, 0);
        add_row(FUNC_WRITE, 12'd64,  12'd0,   12'd0,   16'h8001, 0, 0);
        add_row(FUNC_COUNT, 12'd0,   12'd1,   12'd62,  16'h0003, 0, 0);
        add_row(FUNC_COUNT, 12'd0,   12'd0,   12'd63,  16'h0006, 0, 0);
        add_row(FUNC_COUNT, 12'd0,   12'd63,  12'd64,  16'h8000, 0, 0);
        add_row(FUNC_COUNT, 12'd0,   12'd0,   12'd127, 16'h0000, 0, 0);
        add_row(FUNC_COUNT, 12'd0,   12'd64,  12'hFFF, 16'h7FFF, 0, 0);
        add_row(FUNC_WRITE, 12'hAAA, 12'd0,   12'd0,   16'h5555, 0, 0);
        add_row(FUNC_WRITE, 12'h555, 12'd0,   12'd0,   16'hAAAA, 0, 0);
        add_row(FUNC_COUNT, 12'd0,   12'h555, 12'hAAA, 16'h5554, 0, 0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[k]) send_item(table_rows[k]);

        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == N_RANDOM / 2) begin
                in_ch.valid <= 1'b0;
                while (pending_counts.size() != 0) @(posedge i_clk);
                repeat (BUCKET_SIZE_DEF + 8) @(posedge i_clk);
            end
            if (k == N_RANDOM - CALM_TAIL) calm = 1'b1;
            r = random_row();
            send_item(r);
        end
        in_ch.valid <= 1'b0;

        while (pending_counts.size() != 0) @(posedge i_clk);
        repeat (2 * BUCKET_SIZE_DEF + 16) @(posedge i_clk);

        $display("covered %0d writes and %0d counts, %0d counts compared",
                 n_writes, n_counts, n_checked);
        $display("directed extremes, empty and full ranges, duplicate values, random stalls");
        if (n_errors == 0 && pending_counts.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
